FILE: src/assert_macros.svh
// assertion macros shared by the hash join block
// clock and active-low reset are passed in by each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define HJ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("hash join assertion failed");

// expression must never be true outside reset
`define HJ_NEVER(lbl, clk, rst_n, prop) \
	`HJ_ASSERT(lbl, clk, rst_n, !(prop))

`endif

FILE: src/hjbc_pkg.sv
// shared constants, codes and types of the hash join bucket chain counter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hjbc_pkg;

	localparam int MAX_BUILD_DEF = 1024;

	localparam int KIND_W     = 2;
	localparam int KEY_W      = 32;
	localparam int COUNT_W    = 11;
	localparam int TOTAL_W    = 63;
	localparam int SHIFT_W    = 5;
	localparam int BCOUNT_W   = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [KIND_W-1:0] KIND_START = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BUILD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PROBE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIX_SHIFT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUILD_COUNT = 2'd1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BUILD_WR,
		ST_PROBE_HEAD,
		ST_PROBE_WALK,
		ST_PROBE_DONE
	} state_t;

	typedef struct packed {
		logic join_clear;
		logic sweep;
		logic accept;
		logic build_wr;
		logic hit_from_head;
		logic hit_from_link;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic build_ok;
		logic head_empty;
		logic link_empty;
		logic out_busy;
	} status_t;

endpackage

`default_nettype wire

FILE: src/hjbc_in_if.sv
// input item channel: kind, key and last flag with valid/ready
// depends on hjbc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface hjbc_in_if;
	logic                           valid;
	logic                           ready;
	logic [hjbc_pkg::KIND_W-1:0]    kind;
	logic [hjbc_pkg::KEY_W-1:0]     key;
	logic                           last;

	modport source (output valid, kind, key, last, input ready);
	modport sink (input valid, kind, key, last, output ready);
endinterface

`default_nettype wire

FILE: src/hjbc_out_if.sv
// result channel: per-probe match count, running total and last echo
// depends on hjbc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface hjbc_out_if;
	logic                           valid;
	logic                           ready;
	logic [hjbc_pkg::COUNT_W-1:0]   probe_matches;
	logic [hjbc_pkg::TOTAL_W-1:0]   total_matches;
	logic                           is_last;

	modport source (output valid, probe_matches, total_matches, is_last, input ready);
	modport sink (input valid, probe_matches, total_matches, is_last, output ready);
endinterface

`default_nettype wire

FILE: src/hjbc_cfg_if.sv
// configuration write channel: register index and data with valid/ready
// depends on hjbc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface hjbc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [hjbc_pkg::CFG_IDX_W-1:0]   index;
	logic [hjbc_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/hjbc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module hjbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: src/hjbc_ctrl.sv
// controller state machine: sequences clear sweep, build and probe walk
// depends on hjbc_pkg, drives the datapath through cmd_t and reads status_t
`timescale 1ns / 1ps
`default_nettype none

module hjbc_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	input  wire logic [hjbc_pkg::KIND_W-1:0]   req_kind,
	output logic                               req_ready,
	input  wire hjbc_pkg::status_t             st,
	output hjbc_pkg::cmd_t                     cmd
);

	hjbc_pkg::state_t state_q;
	hjbc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hjbc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			hjbc_pkg::ST_CLEAR: begin
				if (st.sweep_last) begin
					state_d = hjbc_pkg::ST_IDLE;
				end
			end
			hjbc_pkg::ST_IDLE: begin
				if (req_valid) begin
					case (req_kind)
						hjbc_pkg::KIND_START: state_d = hjbc_pkg::ST_CLEAR;
						hjbc_pkg::KIND_BUILD: begin
							state_d = st.build_ok ? hjbc_pkg::ST_BUILD_WR : hjbc_pkg::ST_IDLE;
						end
						hjbc_pkg::KIND_PROBE: state_d = hjbc_pkg::ST_PROBE_HEAD;
						default: state_d = hjbc_pkg::ST_IDLE;
					endcase
				end
			end
			hjbc_pkg::ST_BUILD_WR: state_d = hjbc_pkg::ST_IDLE;
			hjbc_pkg::ST_PROBE_HEAD: begin
				state_d = st.head_empty ? hjbc_pkg::ST_PROBE_DONE : hjbc_pkg::ST_PROBE_WALK;
			end
			hjbc_pkg::ST_PROBE_WALK: begin
				if (st.link_empty) begin
					state_d = hjbc_pkg::ST_PROBE_DONE;
				end
			end
			hjbc_pkg::ST_PROBE_DONE: begin
				if (!st.out_busy) begin
					state_d = hjbc_pkg::ST_IDLE;
				end
			end
			default: state_d = hjbc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			hjbc_pkg::ST_CLEAR: cmd.sweep = 1'b1;
			hjbc_pkg::ST_IDLE: begin
				req_ready      = 1'b1;
				cmd.accept     = req_valid;
				cmd.join_clear = req_valid && (req_kind == hjbc_pkg::KIND_START);
			end
			hjbc_pkg::ST_BUILD_WR: cmd.build_wr = 1'b1;
			hjbc_pkg::ST_PROBE_HEAD: cmd.hit_from_head = 1'b1;
			hjbc_pkg::ST_PROBE_WALK: cmd.hit_from_link = 1'b1;
			hjbc_pkg::ST_PROBE_DONE: cmd.load_out = !st.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: src/hjbc_dp.sv
// datapath: config registers, bucket select, head/link/key rams, counters
// and the result register; depends on hjbc_pkg and hjbc_ram
`timescale 1ns / 1ps
`default_nettype none

module hjbc_dp #(
	parameter int MAX_BUILD = hjbc_pkg::MAX_BUILD_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	input  wire logic [hjbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [hjbc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [hjbc_pkg::KEY_W-1:0]       req_key,
	input  wire logic                             req_last,
	input  wire hjbc_pkg::cmd_t                   cmd,
	output hjbc_pkg::status_t                     st,
	input  wire logic                             rsp_ready,
	output logic                                  rsp_valid,
	output logic [hjbc_pkg::COUNT_W-1:0]          rsp_probe_matches,
	output logic [hjbc_pkg::TOTAL_W-1:0]          rsp_total_matches,
	output logic                                  rsp_is_last
);

	localparam int HBW = $clog2(MAX_BUILD);
	localparam int HD  = 2 ** HBW;
	localparam int AW  = $clog2(MAX_BUILD);
	localparam int PW  = $clog2(MAX_BUILD + 1);
	localparam int BW  = hjbc_pkg::BCOUNT_W;
	localparam int KW  = hjbc_pkg::KEY_W;
	localparam int SW  = hjbc_pkg::SHIFT_W;
	localparam int CW  = hjbc_pkg::COUNT_W;
	localparam int TW  = hjbc_pkg::TOTAL_W;

	function automatic logic [BW-1:0] mask_of(input logic [BW-1:0] n);
		logic [BW-1:0] m;
		m = n - 1'b1;
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		m = m | (m >> 8);
		if (n == '0) begin
			m = '0;
		end
		return m;
	endfunction

	logic [SW-1:0]  radix_shift_q;
	logic [BW-1:0]  build_count_q;
	logic [HBW-1:0] sweep_q;
	logic [PW-1:0]  pos_q;
	logic [TW-1:0]  total_q;
	logic           out_valid_q;
	logic [KW-1:0]  key_q;
	logic           last_q;
	logic [HBW-1:0] bucket_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  out_count_q;
	logic [TW-1:0]  out_total_q;
	logic           out_last_q;

	logic [BW-1:0]  eff;
	logic [BW-1:0]  mask;
	logic [KW-1:0]  shifted;
	logic [KW-1:0]  bsel;
	logic [HBW-1:0] bucket_in;
	logic [PW-1:0]  pos_inc;
	logic [PW-1:0]  head_rdata;
	logic [PW-1:0]  link_rdata;
	logic [KW-1:0]  key_rdata;
	logic [PW-1:0]  chain_hit;
	logic [PW-1:0]  hit_m1;
	logic [AW-1:0]  chain_addr;
	logic           head_we;
	logic [HBW-1:0] head_waddr;
	logic [PW-1:0]  head_wdata;
	logic [TW:0]    sum;
	logic [TW-1:0]  total_nxt;

	assign eff       = (32'(build_count_q) > MAX_BUILD) ? BW'(MAX_BUILD) : build_count_q;
	assign mask      = mask_of(eff);
	assign shifted   = req_key >> radix_shift_q;
	assign bsel      = shifted & KW'(mask);
	assign bucket_in = bsel[HBW-1:0];
	assign pos_inc   = pos_q + PW'(1);

	assign chain_hit  = cmd.hit_from_head ? head_rdata : link_rdata;
	assign hit_m1     = chain_hit - PW'(1);
	assign chain_addr = hit_m1[AW-1:0];

	assign head_we    = cmd.sweep || cmd.build_wr;
	assign head_waddr = cmd.sweep ? sweep_q : bucket_q;
	assign head_wdata = cmd.sweep ? '0 : pos_inc;

	assign sum       = {1'b0, total_q} + (TW + 1)'(count_q);
	assign total_nxt = sum[TW] ? '1 : sum[TW-1:0];

	assign st.sweep_last = &sweep_q;
	assign st.build_ok   = 32'(pos_q) < 32'(eff);
	assign st.head_empty = (head_rdata == '0) || (eff == '0);
	assign st.link_empty = link_rdata == '0;
	assign st.out_busy   = out_valid_q && !rsp_ready;

	hjbc_ram #(.WIDTH(PW), .DEPTH(HD)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (bucket_in),
		.rdata (head_rdata)
	);

	hjbc_ram #(.WIDTH(PW), .DEPTH(MAX_BUILD)) u_link_ram (
		.clk   (clk),
		.we    (cmd.build_wr),
		.waddr (pos_q[AW-1:0]),
		.wdata (head_rdata),
		.raddr (chain_addr),
		.rdata (link_rdata)
	);

	hjbc_ram #(.WIDTH(KW), .DEPTH(MAX_BUILD)) u_key_ram (
		.clk   (clk),
		.we    (cmd.build_wr),
		.waddr (pos_q[AW-1:0]),
		.wdata (key_q),
		.raddr (chain_addr),
		.rdata (key_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_shift_q <= '0;
			build_count_q <= '0;
			sweep_q       <= '0;
			pos_q         <= '0;
			total_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					hjbc_pkg::CFG_RADIX_SHIFT: radix_shift_q <= cfg_data[SW-1:0];
					hjbc_pkg::CFG_BUILD_COUNT: build_count_q <= cfg_data[BW-1:0];
					default: ;
				endcase
			end
			if (cmd.join_clear) begin
				sweep_q <= '0;
				pos_q   <= '0;
				total_q <= '0;
			end else begin
				if (cmd.sweep) begin
					sweep_q <= sweep_q + HBW'(1);
				end
				if (cmd.build_wr) begin
					pos_q <= pos_inc;
				end
				if (cmd.load_out) begin
					total_q <= total_nxt;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q    <= req_key;
			last_q   <= req_last;
			bucket_q <= bucket_in;
		end
		if (cmd.hit_from_head) begin
			count_q <= '0;
		end else if (cmd.hit_from_link) begin
			if ((key_rdata == key_q) && (count_q != hjbc_pkg::COUNT_MAX)) begin
				count_q <= count_q + CW'(1);
			end
		end
		if (cmd.load_out) begin
			out_count_q <= count_q;
			out_total_q <= total_nxt;
			out_last_q  <= last_q;
		end
	end

	assign rsp_valid         = out_valid_q;
	assign rsp_probe_matches = out_count_q;
	assign rsp_total_matches = out_total_q;
	assign rsp_is_last       = out_last_q;

endmodule

`default_nettype wire

FILE: src/hash_join_bucket_chain_count.sv
// Bucket-chaining hash join match counter. A start item clears the bucket
// heads with a sweep over all 2**clog2(MAX_BUILD) entries of the head ram
// (1024 entries at the default size); the same sweep runs after reset
// before the first item is taken. For a build item the head ram is read in
// the transfer cycle and the key, link and new head are written in the next;
// a build that is ignored does nothing beyond the transfer. A probe item
// reads the head, walks the chain through the link and key rams one entry
// per step, then loads the result register, which may wait while an earlier
// result has not been taken. Kind 3 items are taken with no effect.
// Configuration writes are always ready and are written into the config
// registers on transfer.
// depends on hjbc_pkg, the channel interfaces, hjbc_ctrl, hjbc_dp
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hash_join_bucket_chain_count #(
	parameter int MAX_BUILD = hjbc_pkg::MAX_BUILD_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hjbc_cfg_if.sink    cfg,
	hjbc_in_if.sink     req,
	hjbc_out_if.source  rsp
);

	hjbc_pkg::cmd_t    cmd;
	hjbc_pkg::status_t st;

	assign cfg.ready = 1'b1;

	hjbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req.kind),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	hjbc_dp #(.MAX_BUILD(MAX_BUILD)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg.valid),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.req_key           (req.key),
		.req_last          (req.last),
		.cmd               (cmd),
		.st                (st),
		.rsp_ready         (rsp.ready),
		.rsp_valid         (rsp.valid),
		.rsp_probe_matches (rsp.probe_matches),
		.rsp_total_matches (rsp.total_matches),
		.rsp_is_last       (rsp.is_last)
	);

	// probe transfer starts the chain walk from the head read
	`HJ_ASSERT(a_probe_head, clk, arst_n, req.valid && req.ready && req.kind == hjbc_pkg::KIND_PROBE |=> cmd.hit_from_head)
	// result register is never overwritten while a result waits
	`HJ_NEVER(a_load_busy, clk, arst_n, cmd.load_out && rsp.valid && !rsp.ready)
	// no transfer during the head clear sweep
	`HJ_NEVER(a_sweep_accept, clk, arst_n, cmd.sweep && req.ready)
	// loaded result shows up on the output
	`HJ_ASSERT(a_out_valid, clk, arst_n, cmd.load_out |=> rsp.valid)

endmodule

`default_nettype wire
